// ===== hw/rtl/evr_pkg.sv =====
// ----------------------------------------------------------------------------
// Euler vector rotator package
// Trig formats, CORDIC arc table and stage payload types.
// ----------------------------------------------------------------------------
package evr_pkg;

	// sine/cosine are Q2.30 held with headroom
	localparam int TRIG_W    = 34;
	localparam int TRIG_FRAC = 30;
	// CORDIC angle, unit 2^-32 degree
	localparam int ANG_W     = 44;

	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic signed [ANG_W-1:0] DEG_90  = 44'sd386547056640;
	localparam logic signed [ANG_W-1:0] DEG_180 = 44'sd773094113280;
	localparam logic signed [ANG_W-1:0] DEG_360 = 44'sd1546188226560;

	// atan(2^-i) in 2^-32 degree
	localparam logic signed [ANG_W-1:0] ARC_DEG [32] = '{
		44'sd193273528320, 44'sd114096026022, 44'sd60285206653, 44'sd30601712202,
		44'sd15360239180,  44'sd7687607525,   44'sd3844741810,  44'sd1922488225,
		44'sd961258780,    44'sd480631223,    44'sd240315841,   44'sd120157949,
		44'sd60078978,     44'sd30039490,     44'sd15019745,    44'sd7509872,
		44'sd3754936,      44'sd1877468,      44'sd938734,      44'sd469367,
		44'sd234684,       44'sd117342,       44'sd58671,       44'sd29335,
		44'sd14668,        44'sd7334,         44'sd3667,        44'sd1833,
		44'sd917,          44'sd458,          44'sd229,         44'sd115
	};

	typedef struct packed {
		logic signed [TRIG_W-1:0] x;
		logic signed [TRIG_W-1:0] y;
		logic signed [ANG_W-1:0]  d;
		logic                     flip;
		logic                     skip;
	} cord_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] c;
		logic signed [TRIG_W-1:0] s;
		logic                     skip;
	} trig_t;

endpackage

// ===== hw/rtl/euler_vector_rotator_unit.sv =====
// ----------------------------------------------------------------------------
// Euler vector rotator
// Turns a 3D point about a pivot by three angles in degrees, Q16.16.
// ----------------------------------------------------------------------------
// Use:
//  Slave channel carries one transaction per point: s_tdata holds point,
//  angles and pivot, s_tuser holds the command and the order flag.
//  Master channel returns the turned point in m_tdata and the clip flag
//  in m_tuser, one transaction per input transaction, in order.
//  NS is the number of modulo-360 steps (UW - FRACTION_BITS - 9,
//  UW = max(COORD_BITS+2, 41)); one stage per reduction step, one
//  per CORDIC iteration, two per plane turn (multiply, round and clamp).
//  Throughput is one transaction per cycle while the output is not stalled.
//  Reset clears all valid bits; the pipeline is then empty and s_tready high.
//  When the receiver stalls with a result waiting, the whole pipeline holds
//  and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module euler_vector_rotator_unit #(
	parameter int COORD_BITS    = 32,
	parameter int FRACTION_BITS = 16,
	parameter int CORDIC_STAGES = 18,
	localparam int IN_W  = ((9 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((3 * COORD_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// point_x, point_y, point_z, angle_x, angle_y, angle_z, pivot_x, pivot_y, pivot_z
	input  logic [IN_W-1:0]  s_tdata,
	// command, reverse_order
	input  logic [1:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// out_x, out_y, out_z
	output logic [OUT_W-1:0] m_tdata,
	// saturated
	output logic [0:0]       m_tuser
);

	localparam int CB  = COORD_BITS;
	localparam int F   = FRACTION_BITS;
	localparam int CS  = CORDIC_STAGES;
	localparam int TW  = evr_pkg::TRIG_W;
	localparam int AW  = evr_pkg::ANG_W;
	localparam int UW  = (CB + 2 > 41) ? CB + 2 : 41;
	localparam int NS  = UW - 1 - (F + 8);
	localparam int RW  = F + 9;
	localparam int PRW = CB + TW;
	localparam int W1  = PRW + 1;
	localparam int T0  = NS + 2 + CS;
	localparam int L   = T0 + 8;

	localparam logic [UW-1:0] FT   = UW'(360) << F;
	localparam logic [UW-1:0] HALF = UW'(1) << (CB - 1);
	// multiple of a full turn that lifts any angle to non-negative
	localparam logic [UW-1:0] OFFS = ((HALF + FT - UW'(1)) / FT) * FT;
	localparam logic signed [W1-1:0] RND = W1'(1) << (evr_pkg::TRIG_FRAC - 1);

	typedef struct packed {
		logic              cmd;
		logic              rev;
		logic              zero;
		logic              sat;
		logic [2:0][CB-1:0] p;
		logic [2:0][CB-1:0] q;
		logic [2:0][CB-1:0] v;
	} item_t;

	typedef struct packed {
		logic signed [PRW-1:0] ac;
		logic signed [PRW-1:0] sb;
		logic signed [PRW-1:0] sa;
		logic signed [PRW-1:0] cb;
	} prod_t;

	function automatic logic [CB:0] sat_cb(input logic signed [CB+1:0] v);
		logic signed [CB+1:0] hi;
		logic signed [CB+1:0] lo;
		hi = {3'b000, {(CB-1){1'b1}}};
		lo = {3'b111, {(CB-1){1'b0}}};
		if (v > hi) return {1'b1, hi[CB-1:0]};
		if (v < lo) return {1'b1, lo[CB-1:0]};
		return {1'b0, v[CB-1:0]};
	endfunction

	function automatic logic [CB:0] sat_wide(input logic signed [W1-1:0] v);
		logic signed [W1-1:0] hi;
		logic signed [W1-1:0] lo;
		hi = {{(W1-CB+1){1'b0}}, {(CB-1){1'b1}}};
		lo = {{(W1-CB+1){1'b1}}, {(CB-1){1'b0}}};
		if (v > hi) return {1'b1, hi[CB-1:0]};
		if (v < lo) return {1'b1, lo[CB-1:0]};
		return {1'b0, v[CB-1:0]};
	endfunction

	// {angle index, first axis, second axis} of turn t
	function automatic logic [5:0] plane_sel(input int t, input logic rev);
		case (t)
			0:       return rev ? {2'd1, 2'd0, 2'd1} : {2'd2, 2'd1, 2'd2};
			1:       return {2'd0, 2'd2, 2'd0};
			default: return rev ? {2'd2, 2'd1, 2'd2} : {2'd1, 2'd0, 2'd1};
		endcase
	endfunction

	logic [L-1:0]           vld_s;
	logic                   ce;
	item_t                  item_s [L];
	item_t                  item_w;
	item_t                  item_w2;
	item_t                  item_w3;
	logic [2:0][UW-1:0]     red_s [NS+1];
	logic [2:0][UW-1:0]     red_w;
	evr_pkg::cord_t [2:0]   cord_s [CS+1];
	evr_pkg::cord_t [2:0]   cord_w;
	evr_pkg::trig_t [2:0]   trig_w;
	evr_pkg::trig_t [2:0]   trig_s [6];
	prod_t                  prod_s [3];

	assign ce       = ~vld_s[L-1] | m_tready;
	assign s_tready = ce;
	assign m_tvalid = vld_s[L-1];
	assign m_tdata  = OUT_W'(item_s[L-1].v);
	assign m_tuser  = item_s[L-1].sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ce) begin
			vld_s <= {vld_s[L-2:0], s_tvalid};
		end
	end

	// input stage: pivot shift, zero test, angle offset
	always_comb begin
		logic [CB:0] r;
		item_w.cmd  = s_tuser[0];
		item_w.rev  = s_tuser[1] & ~s_tuser[0];
		item_w.sat  = 1'b0;
		item_w.zero = 1'b1;
		for (int k = 0; k < 3; k++) begin
			item_w.p[k] = s_tdata[k*CB +: CB];
			item_w.q[k] = s_tuser[0] ? '0 : s_tdata[(6+k)*CB +: CB];
			if (item_w.p[k] != '0) item_w.zero = 1'b0;
			r = sat_cb($signed({{2{item_w.p[k][CB-1]}}, item_w.p[k]})
				- $signed({{2{item_w.q[k][CB-1]}}, item_w.q[k]}));
			item_w.v[k] = r[CB-1:0];
			item_w.sat  = item_w.sat | r[CB];
			red_w[k] = UW'($signed(s_tdata[(3+k)*CB +: CB])) + OFFS;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			item_s[0] <= item_w;
			red_s[0]  <= red_w;
		end
	end

	for (genvar k = 1; k < T0; k++) begin : g_pass
		always_ff @(posedge clk) begin
			if (ce) item_s[k] <= item_s[k-1];
		end
	end

	// modulo 360, one restoring step a stage
	for (genvar k = 1; k <= NS; k++) begin : g_red
		localparam logic [UW-1:0] STEP = FT << (NS - k);
		always_ff @(posedge clk) begin
			if (ce) begin
				for (int n = 0; n < 3; n++) begin
					red_s[k][n] <= (red_s[k-1][n] >= STEP) ? red_s[k-1][n] - STEP
						: red_s[k-1][n];
				end
			end
		end
	end

	// fold into -90..90 degrees
	for (genvar a = 0; a < 3; a++) begin : g_fold
		always_comb begin
			logic [RW-1:0]          r;
			logic signed [AW-1:0]   d;
			r = red_s[NS][a][RW-1:0];
			d = $signed(AW'(r)) <<< (32 - F);
			cord_w[a].flip = 1'b0;
			if (d > evr_pkg::DEG_180) d = d - evr_pkg::DEG_360;
			if (d > evr_pkg::DEG_90) begin
				d = evr_pkg::DEG_180 - d;
				cord_w[a].flip = 1'b1;
			end else if (d < -evr_pkg::DEG_90) begin
				d = -evr_pkg::DEG_180 - d;
				cord_w[a].flip = 1'b1;
			end
			cord_w[a].d    = d;
			cord_w[a].x    = evr_pkg::CORDIC_GAIN;
			cord_w[a].y    = '0;
			cord_w[a].skip = (r == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (ce) cord_s[0] <= cord_w;
	end

	for (genvar i = 0; i < CS; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (ce) begin
				for (int n = 0; n < 3; n++) begin
					cord_s[i+1][n].flip <= cord_s[i][n].flip;
					cord_s[i+1][n].skip <= cord_s[i][n].skip;
					if (cord_s[i][n].d >= 0) begin
						cord_s[i+1][n].x <= cord_s[i][n].x - (cord_s[i][n].y >>> i);
						cord_s[i+1][n].y <= cord_s[i][n].y + (cord_s[i][n].x >>> i);
						cord_s[i+1][n].d <= cord_s[i][n].d - evr_pkg::ARC_DEG[i];
					end else begin
						cord_s[i+1][n].x <= cord_s[i][n].x + (cord_s[i][n].y >>> i);
						cord_s[i+1][n].y <= cord_s[i][n].y - (cord_s[i][n].x >>> i);
						cord_s[i+1][n].d <= cord_s[i][n].d + evr_pkg::ARC_DEG[i];
					end
				end
			end
		end
	end

	always_comb begin
		for (int n = 0; n < 3; n++) begin
			trig_w[n].c    = cord_s[CS][n].flip ? -cord_s[CS][n].x : cord_s[CS][n].x;
			trig_w[n].s    = cord_s[CS][n].y;
			trig_w[n].skip = cord_s[CS][n].skip;
		end
	end

	// three plane turns, multiply then round and clamp
	for (genvar t = 0; t < 3; t++) begin : g_turn
		evr_pkg::trig_t [2:0] tsrc;
		logic [5:0]           sel_m;
		logic [5:0]           sel_a;
		item_t                nxt;

		if (t == 0) begin : g_first
			assign tsrc = trig_w;
		end else begin : g_later
			assign tsrc = trig_s[2*t-1];
		end

		assign sel_m = plane_sel(t, item_s[T0+2*t-1].rev);
		assign sel_a = plane_sel(t, item_s[T0+2*t].rev);

		always_ff @(posedge clk) begin
			if (ce) begin
				item_s[T0+2*t] <= item_s[T0+2*t-1];
				trig_s[2*t]    <= tsrc;
				prod_s[t].ac   <= tsrc[sel_m[5:4]].c
					* $signed(item_s[T0+2*t-1].v[sel_m[3:2]]);
				prod_s[t].sb   <= tsrc[sel_m[5:4]].s
					* $signed(item_s[T0+2*t-1].v[sel_m[1:0]]);
				prod_s[t].sa   <= tsrc[sel_m[5:4]].s
					* $signed(item_s[T0+2*t-1].v[sel_m[3:2]]);
				prod_s[t].cb   <= tsrc[sel_m[5:4]].c
					* $signed(item_s[T0+2*t-1].v[sel_m[1:0]]);
			end
		end

		always_comb begin
			logic signed [W1-1:0] na;
			logic signed [W1-1:0] nb;
			logic [CB:0]          ra;
			logic [CB:0]          rb;
			na  = (prod_s[t].ac - prod_s[t].sb + RND) >>> evr_pkg::TRIG_FRAC;
			nb  = (prod_s[t].sa + prod_s[t].cb + RND) >>> evr_pkg::TRIG_FRAC;
			ra  = sat_wide(na);
			rb  = sat_wide(nb);
			nxt = item_s[T0+2*t];
			if (!trig_s[2*t][sel_a[5:4]].skip) begin
				nxt.v[sel_a[3:2]] = ra[CB-1:0];
				nxt.v[sel_a[1:0]] = rb[CB-1:0];
				nxt.sat           = nxt.sat | ra[CB] | rb[CB];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				item_s[T0+2*t+1] <= nxt;
				trig_s[2*t+1]    <= trig_s[2*t];
			end
		end
	end

	// back from pivot, then the difference for command 1
	always_comb begin
		logic [CB:0] r;
		item_t       f1;
		item_t       f2;
		f1 = item_s[T0+5];
		for (int k = 0; k < 3; k++) begin
			r = sat_cb($signed({{2{f1.v[k][CB-1]}}, f1.v[k]})
				+ $signed({{2{f1.q[k][CB-1]}}, f1.q[k]}));
			f1.v[k] = r[CB-1:0];
			f1.sat  = f1.sat | r[CB];
		end
		item_w2 = f1;
		f2 = item_s[T0+6];
		if (f2.cmd) begin
			for (int k = 0; k < 3; k++) begin
				r = sat_cb($signed({{2{f2.v[k][CB-1]}}, f2.v[k]})
					- $signed({{2{f2.p[k][CB-1]}}, f2.p[k]}));
				f2.v[k] = r[CB-1:0];
				f2.sat  = f2.sat | r[CB];
			end
		end
		if (f2.zero) begin
			f2.v   = '0;
			f2.sat = 1'b0;
		end
		item_w3 = f2;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			item_s[T0+6] <= item_w2;
			item_s[T0+7] <= item_w3;
		end
	end

endmodule

// ===== hw/rtl/evr_checker.sv =====
// ----------------------------------------------------------------------------
// Euler vector rotator checker
// Port-level checks on stall behaviour, bound to the top level.
// ----------------------------------------------------------------------------
module evr_checker #(
	parameter int COORD_BITS = 32,
	localparam int OUT_W = ((3 * COORD_BITS + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic [0:0]       m_tuser
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// no transaction enters while the output is stalled
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken during output stall");

	// an empty output stage never blocks the input
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with output free");

endmodule

bind euler_vector_rotator_unit evr_checker #(.COORD_BITS(COORD_BITS)) u_evr_checker (.*);

// ===== tb/evr_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Euler vector rotator checker
// Watches both stream channels. For every input transaction it works out the
// turned point from its own fixed-point model (CORDIC, plane turns, clamps)
// and compares each output transaction with the oldest expectation.
// ----------------------------------------------------------------------------
module evr_scoreboard (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [287:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [95:0]  m_tdata,
	input  logic [0:0]   m_tuser,
	output int           fail_count,
	output int           pending
);

	localparam longint CMAX      = 64'sd2147483647;
	localparam longint CMIN      = -64'sd2147483648;
	localparam longint FULL_TURN = 64'sd360 * 64'sd65536;
	localparam longint DEG90     = 64'sd90 <<< 32;
	localparam longint DEG180    = 64'sd180 <<< 32;
	localparam longint DEG360    = 64'sd360 <<< 32;
	localparam longint GAIN      = 64'sd652032874;
	localparam int     STAGES    = 18;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        sat;
	} point_res_t;

	point_res_t turned_q[$];

	function automatic longint clamp_coord(input longint val, inout bit clip);
		if (val > CMAX) begin
			clip = 1'b1;
			return CMAX;
		end
		if (val < CMIN) begin
			clip = 1'b1;
			return CMIN;
		end
		return val;
	endfunction

	// c*a - s*b etc, rounded half up by 2^30 then clamped
	function automatic longint round_q30(input logic signed [127:0] acc, inout bit clip);
		logic signed [127:0] sh;
		sh = (acc + (128'sd1 <<< 29)) >>> 30;
		if (sh > CMAX) begin
			clip = 1'b1;
			return CMAX;
		end
		if (sh < CMIN) begin
			clip = 1'b1;
			return CMIN;
		end
		return longint'(sh);
	endfunction

	function automatic void cordic_sincos(input longint ang, output longint cs, output longint sn);
		longint d, x, y, nx;
		bit flip;
		d = ang;
		x = GAIN;
		y = 0;
		flip = 1'b0;
		if (d > DEG180) d -= DEG360;
		if (d > DEG90) begin
			d = DEG180 - d;
			flip = 1'b1;
		end else if (d < -DEG90) begin
			d = -DEG180 - d;
			flip = 1'b1;
		end
		for (int i = 0; i < STAGES; i++) begin
			if (d >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				d -= evr_pkg::ARC_DEG[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				d += evr_pkg::ARC_DEG[i];
			end
			x = nx;
		end
		cs = flip ? -x : x;
		sn = y;
	endfunction

	// plane 0: x-z, 1: x-y, 2: y-z
	function automatic void turn_plane(inout longint v[3], input int plane, input longint ang,
			inout bit clip);
		longint r, c, s, na, nb;
		int ia, ib;
		r = ang % FULL_TURN;
		if (r < 0) r += FULL_TURN;
		if (r == 0) return;
		cordic_sincos(r <<< 16, c, s);
		case (plane)
			0: begin ia = 2; ib = 0; end
			1: begin ia = 0; ib = 1; end
			default: begin ia = 1; ib = 2; end
		endcase
		na = round_q30(128'(c) * 128'(v[ia]) - 128'(s) * 128'(v[ib]), clip);
		nb = round_q30(128'(s) * 128'(v[ia]) + 128'(c) * 128'(v[ib]), clip);
		v[ia] = na;
		v[ib] = nb;
	endfunction

	function automatic point_res_t rotate_point(input logic [287:0] d, input logic [1:0] u);
		longint pt[3], ang[3], pv[3], v[3], res[3];
		bit cmd, rev, clip;
		point_res_t r;
		cmd = u[0];
		rev = u[1] && !cmd;
		clip = 1'b0;
		for (int k = 0; k < 3; k++) begin
			pt[k]  = longint'($signed(d[32*k +: 32]));
			ang[k] = longint'($signed(d[32*(k+3) +: 32]));
			pv[k]  = cmd ? 0 : longint'($signed(d[32*(k+6) +: 32]));
		end
		if (pt[0] == 0 && pt[1] == 0 && pt[2] == 0) begin
			res = '{0, 0, 0};
		end else begin
			for (int k = 0; k < 3; k++) v[k] = clamp_coord(pt[k] - pv[k], clip);
			if (rev) begin
				turn_plane(v, 1, ang[1], clip);
				turn_plane(v, 0, ang[0], clip);
				turn_plane(v, 2, ang[2], clip);
			end else begin
				turn_plane(v, 2, ang[2], clip);
				turn_plane(v, 0, ang[0], clip);
				turn_plane(v, 1, ang[1], clip);
			end
			for (int k = 0; k < 3; k++) begin
				res[k] = clamp_coord(v[k] + pv[k], clip);
				if (cmd) res[k] = clamp_coord(res[k] - pt[k], clip);
			end
		end
		r.x = res[0][31:0];
		r.y = res[1][31:0];
		r.z = res[2][31:0];
		r.sat = clip;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		point_res_t exp_r, got;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready)
				turned_q.insert(turned_q.size(), rotate_point(s_tdata, s_tuser));
			if (m_tvalid && m_tready) begin
				got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser[0]};
				if (turned_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected output transaction: %h sat %b", m_tdata, m_tuser);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = turned_q.pop_front();
					if (got !== exp_r) begin
						if (fail_count < 10)
							$display("mismatch: exp x %h y %h z %h sat %b, got x %h y %h z %h sat %b",
								exp_r.x, exp_r.y, exp_r.z, exp_r.sat,
								got.x, got.y, got.z, got.sat);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= turned_q.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Euler vector rotator testbench
// Directed corner points, then random points over three idling regimes,
// with one long output stall and one drain pause; the checker judges.
// ----------------------------------------------------------------------------
module tb_top;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [287:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [95:0]  m_tdata;
	logic [0:0]   m_tuser;
	int           fail_count;
	int           pending;

	int send_idle = 9;
	int recv_idle = 74;
	bit stall_req = 1'b0;

	localparam logic [31:0] MAXV = 32'h7fffffff;
	localparam logic [31:0] MINV = 32'h80000000;

	always #5 clk = ~clk;

	euler_vector_rotator_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	evr_scoreboard u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending)
	);

	function automatic logic [31:0] deg(input int n);
		return 32'(n) << 16;
	endfunction

	// order: point xyz, angle xyz, pivot xyz
	task automatic send_point(input bit cmd, input bit rev, input logic [31:0] f[9]);
		logic [287:0] d;
		for (int k = 0; k < 9; k++) d[32*k +: 32] = f[k];
		s_tvalid <= 1'b1;
		s_tuser <= {rev, cmd};
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(2000)) - 1000) << 16;
			2: return 32'($signed($urandom_range(200000)) - 100000);
			default: return $urandom_range(1) ? MAXV - $urandom_range(3) : MINV + $urandom_range(3);
		endcase
	endfunction

	function automatic logic [31:0] rand_angle();
		case ($urandom_range(4))
			0: return $urandom();
			1: return deg($urandom_range(720) - 360);
			2: return deg(90 * ($urandom_range(8) - 4));
			3: return 32'($signed($urandom_range(47185920)) - 23592960);
			default: return '0;
		endcase
	endfunction

	task automatic send_random();
		logic [31:0] f[9];
		for (int k = 0; k < 9; k++) f[k] = (k < 3 || k > 5) ? rand_coord() : rand_angle();
		if ($urandom_range(15) == 0) begin
			f[0] = '0; f[1] = '0; f[2] = '0;
		end
		if ($urandom_range(3) == 0) begin
			f[6] = '0; f[7] = '0; f[8] = '0;
		end
		send_point($urandom_range(1), $urandom_range(1), f);
	endtask

	always @(posedge clk) begin
		if (stall_req) begin
			m_tready <= 1'b0;
			repeat (400) @(posedge clk);
			stall_req = 1'b0;
		end
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		#5000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic [31:0] f[9];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero point with nonzero pivot passes through as zero
		f = '{'0, '0, '0, deg(30), deg(45), deg(60), deg(5), deg(6), deg(7)};
		send_point(0, 0, f);
		send_point(1, 1, f);
		// all angles zero, full turn and negative full turn
		f = '{deg(3), deg(-4), deg(5), '0, deg(360), deg(-360), deg(1), deg(1), deg(1)};
		send_point(0, 0, f);
		// quarter, half, three-quarter turns in both orders
		for (int a = 90; a <= 270; a += 90) begin
			f = '{deg(1), deg(2), deg(3), deg(a), deg(-a), deg(a), '0, '0, '0};
			send_point(0, 0, f);
			send_point(0, 1, f);
			send_point(1, 0, f);
		end
		// field extremes: saturation through pivot and turn
		f = '{MAXV, MINV, MAXV, deg(45), deg(45), deg(45), MINV, MAXV, MINV};
		send_point(0, 0, f);
		send_point(0, 1, f);
		send_point(1, 1, f);
		f = '{MINV, MINV, MINV, MAXV, MINV, MAXV, MAXV, MAXV, MAXV};
		send_point(0, 1, f);
		send_point(1, 0, f);
		f = '{MAXV, MAXV, MAXV, MINV, MAXV, MINV, '0, '0, '0};
		send_point(0, 0, f);
		f = '{32'hffffffff, 32'h1, '0, 32'h1, 32'hffffffff, deg(180), 32'h1, '0, '0};
		send_point(0, 0, f);
		send_point(1, 0, f);

		for (int n = 0; n < 2000; n++) begin
			if (n == 700) begin
				send_idle = 74;
				recv_idle = 9;
			end
			if (n == 1000) stall_req = 1'b1;
			if (n == 1300) begin
				send_idle = 0;
				recv_idle = 0;
			end
			if (n == 1600) begin
				s_tvalid <= 1'b0;
				wait (pending == 0);
				@(posedge clk);
			end
			send_random();
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (60) @(posedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
